@@ rtl/esc_pkg.sv @@
// Package with payload types, constants and helpers for the sensor compensation block.
package esc_pkg;

  localparam int CfgW = 48;
  localparam int DivW = 32;

  typedef enum logic [2:0] {
    REG_TEMP    = 3'd0,
    REG_PRESS_A = 3'd1,
    REG_PRESS_B = 3'd2,
    REG_PRESS_C = 3'd3,
    REG_HUM_A   = 3'd4,
    REG_HUM_B   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } in_item_t;

  typedef struct packed {
    logic signed [25:0] temp_degrees;
    logic [6:0]         hum_percent;
    logic [31:0]        press_pascal;
    logic               press_valid;
  } out_item_t;

  localparam logic [31:0] HumMax = 32'd419430400;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int s);
    return 32'($signed(x) >>> s);
  endfunction

  // Low 32 bits of a product of two 32-bit words.
  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    return 32'(a * b);
  endfunction

endpackage

@@ rtl/esc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a tag carried alongside.
module esc_div #(
  parameter int W = esc_pkg::DivW,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  input  logic [TW-1:0] tag_in,
  output logic          out_vld,
  output logic [W-1:0]  quo,
  output logic [TW-1:0] tag_out
);
  logic [W-1:0]  q_r   [W+1];
  logic [W:0]    rem_r [W+1];
  logic [W-1:0]  d_r   [W+1];
  logic [TW-1:0] t_r   [W+1];
  logic          v_r   [W+1];

  always_comb begin
    q_r[0]   = num;
    rem_r[0] = '0;
    d_r[0]   = den;
    t_r[0]   = tag_in;
    v_r[0]   = in_vld;
  end

  for (genvar i = 0; i < W; i++) begin : g_st
    logic [W:0] sh;
    logic [W:0] df;
    assign sh = {rem_r[i][W-1:0], q_r[i][W-1]};
    assign df = sh - {1'b0, d_r[i]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_r[i+1] <= v_r[i];
      end
      if (adv) begin
        rem_r[i+1] <= df[W] ? sh : df;
        q_r[i+1]   <= {q_r[i][W-2:0], ~df[W]};
        d_r[i+1]   <= d_r[i];
        t_r[i+1]   <= t_r[i];
      end
    end
  end

  assign out_vld = v_r[W];
  assign quo     = q_r[W];
  assign tag_out = t_r[W];
endmodule

@@ rtl/environmental_sensor_compensation_top.sv @@
// Top level of the sensor compensation pipeline.
//
//  Port group   Direction  Handshake
//  in_*         input      in_valid / in_stall
//  out_*        output     out_valid / out_stall
//  cfg_*        input      cfg_we, no handshake back
//
// One transaction can enter every cycle while in_stall is low; the pipeline has 14 stages before
// the 32-stage pressure divider, two correction stages and the output register.
// All stages advance together when the output register is free.
// rst_n is synchronous; it clears the valid bits and the configuration registers.
// A stall holds every stage, so nothing is lost or repeated.
module environmental_sensor_compensation_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  esc_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output esc_pkg::out_item_t       out_data,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [esc_pkg::CfgW-1:0] cfg_wdata
);
  import esc_pkg::*;

  localparam int NS = 14;  // stages before the divider

  logic [47:0] tc_r, pa_r, pb_r, pc_r;
  logic [31:0] ha_r;
  logic [39:0] hb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= '0; pa_r <= '0; pb_r <= '0; pc_r <= '0; ha_r <= '0; hb_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_TEMP:    tc_r <= cfg_wdata;
        REG_PRESS_A: pa_r <= cfg_wdata;
        REG_PRESS_B: pb_r <= cfg_wdata;
        REG_PRESS_C: pc_r <= cfg_wdata;
        REG_HUM_A:   ha_r <= cfg_wdata[31:0];
        REG_HUM_B:   hb_r <= cfg_wdata[39:0];
        default: ;
      endcase
    end
  end

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
  assign t1 = {16'd0, tc_r[15:0]};
  assign t2 = sx16(tc_r[31:16]);
  assign t3 = sx16(tc_r[47:32]);
  assign p1 = {16'd0, pa_r[15:0]};
  assign p2 = sx16(pa_r[31:16]);
  assign p3 = sx16(pa_r[47:32]);
  assign p4 = sx16(pb_r[15:0]);
  assign p5 = sx16(pb_r[31:16]);
  assign p6 = sx16(pb_r[47:32]);
  assign p7 = sx16(pc_r[15:0]);
  assign p8 = sx16(pc_r[31:16]);
  assign p9 = sx16(pc_r[47:32]);
  assign h1 = {24'd0, ha_r[7:0]};
  assign h2 = sx16(ha_r[23:8]);
  assign h3 = {24'd0, ha_r[31:24]};
  assign h4 = sx16(hb_r[15:0]);
  assign h5 = sx16(hb_r[31:16]);
  assign h6 = {{24{hb_r[39]}}, hb_r[39:32]};

  // Output register and global advance.
  logic adv;
  logic ov_r;
  out_item_t od_r;
  logic div_vld;

  assign adv      = !ov_r || !out_stall;
  assign in_stall = !adv;

  // Pre-divider pipeline: each stage holds a general working set.
  typedef struct packed {
    logic [19:0] tr, pr;
    logic [15:0] hr;
    logic [31:0] a, b, fine, v, x, y, sq, pa, pb, pd, t100, hum;
  } wk_t;

  wk_t  s_r   [NS+1];
  logic sv_r  [NS+1];
  wk_t  s_nxt [NS];

  always_comb begin
    s_r[0]  = '0;
    s_r[0].tr = in_data.raw_temp;
    s_r[0].pr = in_data.raw_press;
    s_r[0].hr = in_data.raw_hum;
    sv_r[0] = in_valid;
  end

  always_comb begin
    for (int i = 0; i < NS; i++) s_nxt[i] = s_r[i];
    // 1: temperature products
    s_nxt[0].a = mul32(({12'd0, s_r[0].tr[19:3]} - (t1 << 1)), t2);
    s_nxt[0].b = ({12'd0, s_r[0].tr[19:4]} - t1);
    s_nxt[0].b = mul32(s_nxt[0].b, s_nxt[0].b);
    // 2
    s_nxt[1].a = asr(s_r[1].a, 11);
    s_nxt[1].b = asr(mul32(asr(s_r[1].b, 12), t3), 14);
    // 3: fine value
    s_nxt[2].fine = s_r[2].a + s_r[2].b;
    // 4: hundredths, humidity / pressure offsets
    s_nxt[3].t100 = asr(mul32(s_r[3].fine, 32'd5) + 32'd128, 8);
    s_nxt[3].v    = s_r[3].fine - 32'd76800;
    s_nxt[3].pa   = asr(s_r[3].fine, 1) - 32'd64000;
    // 5
    s_nxt[4].x  = ({s_r[4].hr, 14'd0}) - (h4 << 20) - mul32(h5, s_r[4].v) + 32'd16384;
    s_nxt[4].y  = asr(mul32(s_r[4].v, h6), 10);
    s_nxt[4].b  = asr(mul32(s_r[4].v, h3), 11) + 32'd32768;
    s_nxt[4].sq = mul32(asr(s_r[4].pa, 2), asr(s_r[4].pa, 2));
    // 6
    s_nxt[5].x  = asr(s_r[5].x, 15);
    s_nxt[5].y  = mul32(s_r[5].y, s_r[5].b);
    s_nxt[5].pb = mul32(asr(s_r[5].sq, 11), p6);
    s_nxt[5].a  = mul32(s_r[5].pa, p5) << 1;
    // 7
    s_nxt[6].y  = mul32(asr(s_r[6].y, 10) + 32'd2097152, h2) + 32'd8192;
    s_nxt[6].pb = asr(s_r[6].pb + s_r[6].a, 2) + (p4 << 16);
    s_nxt[6].a  = mul32(p3, asr(s_r[6].sq, 13));
    s_nxt[6].b  = mul32(p2, s_r[6].pa);
    // 8
    s_nxt[7].y  = mul32(s_r[7].x, asr(s_r[7].y, 14));
    s_nxt[7].a  = asr(asr(s_r[7].a, 3) + asr(s_r[7].b, 1), 18);
    // 9
    s_nxt[8].sq = asr(s_r[8].y, 15);
    s_nxt[8].pd = mul32(32'd32768 + s_r[8].a, p1);
    // 10
    s_nxt[9].sq = mul32(s_r[9].sq, s_r[9].sq);
    s_nxt[9].pd = asr(s_r[9].pd, 15);
    s_nxt[9].a  = (32'd1048576 - {12'd0, s_r[9].pr}) - asr(s_r[9].pb, 12);
    // 11
    s_nxt[10].sq = mul32(asr(s_r[10].sq, 7), h1);
    s_nxt[10].a  = mul32(s_r[10].a, 32'd3125);
    // 12: clamp humidity
    s_nxt[11].v = s_r[11].y - asr(s_r[11].sq, 4);
    if (s_nxt[11].v[31]) s_nxt[11].v = '0;
    else if (s_nxt[11].v > HumMax) s_nxt[11].v = HumMax;
    // 13: percent = v >> 22 (v>>12 then /1024); magnitude of t100 for degrees = t100 / 100
    s_nxt[12].hum = {22'd0, s_r[12].v[31:22]};
    s_nxt[12].x   = s_r[12].t100[31] ? (32'd0 - s_r[12].t100) : s_r[12].t100;
    // 14: magnitude / 100 via reciprocal (x < 2^25 here, exact for that range)
    s_nxt[13].x = 32'((64'(s_r[13].x) * 64'd1374389535) >> 37);
  end

  for (genvar i = 0; i < NS; i++) begin : g_pre
    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[i+1] <= 1'b0;
      else if (adv) sv_r[i+1] <= sv_r[i];
      if (adv) s_r[i+1] <= s_nxt[i];
    end
  end

  // Divider setup: numerator and post-scale flag.
  logic [31:0] pnum;
  logic        big;
  assign big  = s_r[NS].a[31];
  assign pnum = big ? s_r[NS].a : (s_r[NS].a << 1);

  localparam int TagW = 26 + 7 + 1 + 1;
  logic [TagW-1:0] tag_in, tag_out;
  logic [25:0] deg;
  assign deg    = s_r[NS].t100[31] ? 26'(32'd0 - s_r[NS].x) : s_r[NS].x[25:0];
  assign tag_in = {deg, s_r[NS].hum[6:0], s_r[NS].pd != 32'd0, big};

  logic [31:0] quo;
  esc_div #(.W(DivW), .TW(TagW)) u_div (
    .clk, .rst_n, .adv, .in_vld(sv_r[NS]), .num(pnum), .den(s_r[NS].pd),
    .tag_in, .out_vld(div_vld), .quo, .tag_out
  );

  // Post-divider correction, two stages.
  logic        q1v_r, q2v_r;
  logic [31:0] q1p_r, q1a_r, q1b_r, q2p_r;
  logic [TagW-1:0] q1t_r, q2t_r;
  logic [31:0] pq, p3s;
  assign pq  = tag_out[0] ? (quo << 1) : quo;
  assign p3s = pq >> 3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1v_r <= 1'b0; q2v_r <= 1'b0; ov_r <= 1'b0;
    end else if (adv) begin
      q1v_r <= div_vld; q2v_r <= q1v_r; ov_r <= q2v_r;
    end
    if (adv) begin
      q1p_r <= pq;
      q1a_r <= mul32(p3s, p3s) >> 13;
      q1b_r <= asr(mul32(pq >> 2, p8), 13);
      q1t_r <= tag_out;
      q2p_r <= q1p_r + asr(asr(mul32(p9, q1a_r), 12) + q1b_r + p7, 4);
      q2t_r <= q1t_r;
      od_r.temp_degrees <= q2t_r[TagW-1 -: 26];
      od_r.hum_percent  <= q2t_r[8:2];
      od_r.press_valid  <= q2t_r[1];
      od_r.press_pascal <= q2t_r[1] ? q2p_r : 32'd0;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  a_inv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.press_valid |-> out_data.press_pascal == 32'd0)
    else $error("invalid pressure not zero");
  a_hum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.hum_percent <= 7'd100)
    else $error("humidity above range");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ov_r && out_stall)
    else $error("input stalled without output stall");
endmodule
